// File: rtl/core/ile_pkg.sv
// ile_pkg: request and status codes plus the result bundle for the indexed list engine
// no dependencies; imported by ile_seq and indexed_list_engine
package ile_pkg;

    // request codes
    localparam logic [2:0] REQ_GET       = 3'd0;
    localparam logic [2:0] REQ_APPEND    = 3'd1;
    localparam logic [2:0] REQ_DELETE    = 3'd2;
    localparam logic [2:0] REQ_INSERT    = 3'd3;
    localparam logic [2:0] REQ_OVERWRITE = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // one finished result
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic [6:0]         length;
    } ile_res_t;

endpackage

// File: rtl/core/indexed_list_engine.sv
// indexed_list_engine: ordered list of signed 32-bit items with get, append, delete, insert
// and overwrite by position; depends on ile_pkg, ile_mem and ile_seq
//
// usage
//  - requests arrive on the s_ channel (valid/ready); one transfer is one request
//  - every request gives exactly one result transfer on the m_ channel: status, the item
//    read (zero unless a successful get) and the list length after the request
//  - the block takes one request at a time; s_ready is low while a request is in work
//  - append, overwrite and rejected requests go straight to the result state; get passes
//    through a read state; delete or insert walk the store in the move state, moving n
//    entries (length - position - 1 for delete, length - position for insert)
//  - the move rate is set by the single store: one read and one write port, one entry
//    moved per cycle, overlapped read and write-back
//  - a result waits in an output register; the next request is taken while it waits,
//    and its own result is held back until the register is free
//  - reset (aresetn low, synchronous) empties the list and drops any pending result;
//    the store itself is not cleared, entries beyond the length are never read
//  - bad positions give status 1 and full list gives status 2, list unchanged
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int LIST_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_req_type,
    input  logic [6:0]          s_position,
    input  logic signed [31:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic signed [31:0]  m_read_value,
    output logic [6:0]          m_length
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [6:0] DEPTH_LEN = 7'(LIST_DEPTH % 128);

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_data;
    logic               res_valid;
    logic               res_ready;
    ile_res_t           res;

    logic               out_valid_reg, out_valid_next;
    ile_res_t           out_res_reg, out_res_next;

    ile_mem #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ile_seq #(
        .LIST_DEPTH (LIST_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_position (s_position),
        .s_value    (s_value),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output register, free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_res_reg.status;
    assign m_read_value = out_res_reg.value;
    assign m_length     = out_res_reg.length;

    // a request transfer always leaves the block busy in the next cycle
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block ready right after a request transfer");

    // only a successful get carries a read value
    a_value_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_BAD_POS || m_status == ST_FULL) |-> m_read_value == 32'sd0)
        else $error("read value not zero on a rejected request");

    // a full report comes only with the list at capacity
    a_full_at_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_length == DEPTH_LEN)
        else $error("full status with list below capacity");

endmodule

// File: rtl/core/ile_mem.sv
// ile_mem: single write port, single read port item store with registered read data
// no dependencies; instantiated by indexed_list_engine
module ile_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [31:0]  rd_data
);

    logic signed [31:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/ile_seq.sv
// ile_seq: request decode, item count and the sequencer that walks the store one entry a cycle
// depends on ile_pkg; drives the ports of ile_mem
module ile_seq
    import ile_pkg::*;
#(
    parameter int LIST_DEPTH = 64,
    parameter int AW         = 6,
    parameter int CW         = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_req_type,
    input  logic [6:0]          s_position,
    input  logic signed [31:0]  s_value,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic signed [31:0]  wr_data,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic signed [31:0]  rd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output ile_res_t            res
);

    localparam int CMPW = (CW > 7) ? CW : 7;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GET  = 4'b0010,
        S_MOVE = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [CW-1:0]      dst_reg, dst_next;
    logic               del_reg, del_next;
    logic [CMPW-1:0]    pos_reg, pos_next;
    logic signed [31:0] val_reg, val_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] value_reg, value_next;

    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    cnt_ext;
    logic               pos_in_range;
    logic               pos_ins_ok;
    logic               is_full;
    logic [CW-1:0]      ptr_step;
    logic               more;
    logic               accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    // position checks against the current count
    assign pos_ext      = CMPW'(s_position);
    assign cnt_ext      = CMPW'(count_reg);
    assign pos_in_range = pos_ext < cnt_ext;
    assign pos_ins_ok   = pos_ext <= cnt_ext;
    assign is_full      = (count_reg == CW'(LIST_DEPTH));

    // shared step unit: one increment or decrement and one compare per cycle
    assign ptr_step = del_reg ? (ptr_reg + CW'(1)) : (ptr_reg - CW'(1));
    assign more     = del_reg ? (ptr_step < count_reg) : (CMPW'(ptr_reg) > pos_reg);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        pend_next   = pend_reg;
        dst_next    = dst_reg;
        del_next    = del_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        status_next = status_reg;
        value_next  = value_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = s_value;
        rd_en       = 1'b0;
        rd_addr     = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pos_next    = pos_ext;
                    val_next    = s_value;
                    status_next = ST_OK;
                    value_next  = '0;
                    pend_next   = 1'b0;
                    state_next  = S_FIN;
                    case (s_req_type)
                        REQ_GET: begin
                            if (pos_in_range) begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_ext[AW-1:0];
                                state_next = S_GET;
                            end else begin
                                status_next = ST_BAD_POS;
                            end
                        end
                        REQ_APPEND: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_DELETE: begin
                            if (pos_in_range) begin
                                del_next   = 1'b1;
                                ptr_next   = CW'(pos_ext);
                                state_next = S_MOVE;
                            end else begin
                                status_next = ST_BAD_POS;
                            end
                        end
                        REQ_INSERT: begin
                            if (!pos_ins_ok) begin
                                status_next = ST_BAD_POS;
                            end else if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                del_next   = 1'b0;
                                ptr_next   = count_reg;
                                state_next = S_MOVE;
                            end
                        end
                        REQ_OVERWRITE: begin
                            if (pos_in_range) begin
                                wr_en   = 1'b1;
                                wr_addr = pos_ext[AW-1:0];
                            end else begin
                                status_next = ST_BAD_POS;
                            end
                        end
                        default: begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_GET: begin
                value_next = rd_data;
                state_next = S_FIN;
            end
            S_MOVE: begin
                // read the next source entry while the previous one is written back
                if (more) begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_step[AW-1:0];
                    pend_next = 1'b1;
                    dst_next  = ptr_reg;
                    ptr_next  = ptr_step;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg[AW-1:0];
                    wr_data = rd_data;
                end else if (!more) begin
                    if (del_reg) begin
                        count_next = count_reg - CW'(1);
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = pos_reg[AW-1:0];
                        wr_data    = val_reg;
                        count_next = count_reg + CW'(1);
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // request payload and working registers
    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        dst_reg    <= dst_next;
        del_reg    <= del_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    // result towards the output register
    assign res_valid  = (state_reg == S_FIN);
    assign res.status = status_reg;
    assign res.value  = value_reg;
    assign res.length = cnt_ext[6:0];

endmodule
